// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the scanner top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge, held off while reset is high.
`define FDSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define FDSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDSS_ASSERT(lbl, clk, rst, prop, msg)
`define FDSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/fdss_pkg.sv =====
package fdss_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int CODE_W     = 5;

   // character codes
   localparam logic [CODE_W-1:0] CODE_ZERO  = 5'd0;
   localparam logic [CODE_W-1:0] CODE_BLANK = 5'd16;
   localparam logic [CODE_W-1:0] CODE_L     = 5'd17;
   localparam logic [CODE_W-1:0] CODE_DASH  = 5'd18;
   localparam logic [CODE_W-1:0] CODE_MAX   = 5'd18;

   localparam logic [15:0] INT_MAX_SHOWN = 16'd9999;

   // transaction functions
   localparam logic [1:0] FUNC_TICK      = 2'd0;
   localparam logic [1:0] FUNC_SET_INT   = 2'd1;
   localparam logic [1:0] FUNC_SET_DIGIT = 2'd2;
   localparam logic [1:0] FUNC_SET_ALL   = 2'd3;

   // dot modes
   localparam logic [1:0] DOTS_OFF   = 2'd0;
   localparam logic [1:0] DOTS_BOTH  = 2'd1;
   localparam logic [1:0] DOTS_UPPER = 2'd2;
   localparam logic [1:0] DOTS_LOWER = 2'd3;

   // register byte addresses
   localparam logic [1:0] REG_DOTS_MODE = 2'd0;

   localparam logic [7:0] SEG_ALL_OFF = 8'hFF;
   localparam logic [3:0] EN_ALL_OFF  = 4'hF;

   typedef logic [CODE_W-1:0] code_type;
   typedef code_type [NUM_DIGITS-1:0] codes_type;

   // thousands split of a set-integer value
   typedef struct packed {
      logic       overload;
      logic [3:0] thousands;
      logic [9:0] rem;
   } split_type;

   // contents of the input stage register
   typedef struct packed {
      logic [1:0] func;
      logic [1:0] digit_index;
      code_type   single_code;
      codes_type  all_codes;
      split_type  split;
   } req_stage_type;

   // out-of-range codes are stored as blank
   function automatic code_type clamp_code(input logic [15:0] c);
      code_type r;
      r = (c > 16'(CODE_MAX)) ? CODE_BLANK : c[CODE_W-1:0];
      return r;
   endfunction

   // active-low segment pattern, a..g in bits 0-6, dot in bit 7
   function automatic logic [7:0] glyph(input code_type c);
      logic [7:0] s;
      unique case (c)
         5'd0:    s = 8'hC0;
         5'd1:    s = 8'hF9;
         5'd2:    s = 8'hA4;
         5'd3:    s = 8'hB0;
         5'd4:    s = 8'h99;
         5'd5:    s = 8'h92;
         5'd6:    s = 8'h82;
         5'd7:    s = 8'hF8;
         5'd8:    s = 8'h80;
         5'd9:    s = 8'h90;
         5'd10:   s = 8'h88;
         5'd11:   s = 8'h83;
         5'd12:   s = 8'hC6;
         5'd13:   s = 8'hA1;
         5'd14:   s = 8'h86;
         5'd15:   s = 8'h8E;
         5'd17:   s = 8'hC7;
         5'd18:   s = 8'hBF;
         default: s = SEG_ALL_OFF;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/fdss_csr.sv =====
module fdss_csr
   import fdss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [1:0]  dots_mode
);

   logic [1:0] dots_mode_ff;
   logic [1:0] dots_mode_in;
   logic       wr_en;

   // write lands in the access phase
   assign wr_en = psel && penable && pwrite && (paddr == REG_DOTS_MODE);
   assign dots_mode_in = wr_en ? pwdata[1:0] : dots_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dots_mode_ff <= DOTS_OFF;
      end else begin
         dots_mode_ff <= dots_mode_in;
      end
   end

   assign prdata    = (paddr == REG_DOTS_MODE) ? {30'd0, dots_mode_ff} : 32'd0;
   assign pready    = 1'b1;
   assign dots_mode = dots_mode_ff;

endmodule

// ===== rtl/core/fdss_int_split.sv =====
module fdss_int_split
   import fdss_pkg::*;
(
   input  logic [15:0] value,
   output split_type   split
);

   logic [13:0] v14;
   logic [13:0] base;
   logic [3:0]  th;

   // thousands digit by parallel compares against the multiples of 1000
   always_comb begin
      v14  = value[13:0];
      th   = 4'd0;
      base = 14'd0;
      for (int i = 1; i < 10; i++) begin
         if (v14 >= 14'(i * 1000)) begin
            th   = 4'(i);
            base = 14'(i * 1000);
         end
      end
   end

   assign split.overload  = (value > INT_MAX_SHOWN);
   assign split.thousands = th;
   assign split.rem       = 10'(v14 - base);

endmodule

// ===== rtl/core/fdss_dec_low.sv =====
module fdss_dec_low
   import fdss_pkg::*;
(
   input  split_type split,
   output codes_type codes
);

   logic [3:0] hund;
   logic [9:0] hund_base;
   logic [6:0] r2;
   logic [3:0] tens;
   logic [6:0] tens_base;
   logic [3:0] units;

   // hundreds from the sub-thousand remainder
   always_comb begin
      hund      = 4'd0;
      hund_base = 10'd0;
      for (int i = 1; i < 10; i++) begin
         if (split.rem >= 10'(i * 100)) begin
            hund      = 4'(i);
            hund_base = 10'(i * 100);
         end
      end
   end

   assign r2 = 7'(split.rem - hund_base);

   // tens and units from the sub-hundred remainder
   always_comb begin
      tens      = 4'd0;
      tens_base = 7'd0;
      for (int i = 1; i < 10; i++) begin
         if (r2 >= 7'(i * 10)) begin
            tens      = 4'(i);
            tens_base = 7'(i * 10);
         end
      end
   end

   assign units = 4'(r2 - tens_base);

   // overload shows blank, blank, 0, L
   always_comb begin
      if (split.overload) begin
         codes[0] = CODE_BLANK;
         codes[1] = CODE_BLANK;
         codes[2] = CODE_ZERO;
         codes[3] = CODE_L;
      end else begin
         codes[0] = {1'b0, split.thousands};
         codes[1] = {1'b0, hund};
         codes[2] = {1'b0, tens};
         codes[3] = {1'b0, units};
      end
   end

endmodule

// ===== rtl/core/fdss_drive.sv =====
module fdss_drive
   import fdss_pkg::*;
(
   input  codes_type  codes,
   input  logic [1:0] scan,
   input  logic [1:0] dots_mode,
   output logic [7:0] segments_n,
   output logic [3:0] digit_enable_n
);

   logic [7:0] pattern;
   logic       dot_on;

   assign pattern = glyph(codes[scan]);

   // dot on digit 2 for upper/both, on digit 3 for lower/both
   assign dot_on = ((scan == 2'd2) && (dots_mode == DOTS_BOTH || dots_mode == DOTS_UPPER))
                || ((scan == 2'd3) && (dots_mode == DOTS_BOTH || dots_mode == DOTS_LOWER));

   assign segments_n     = {pattern[7] & ~dot_on, pattern[6:0]};
   assign digit_enable_n = ~(4'b0001 << scan);

endmodule

// ===== rtl/core/four_digit_seven_segment_scanner.sv =====
// Multiplexed driver for a four-digit common-anode seven-segment display.
// Each request transaction (refresh tick, set integer, set one digit, set all
// codes) returns one response carrying the held segment and digit-enable drive
// and the scan position. A transaction can be accepted every cycle while the
// response side keeps up. A request passes the input stage register and then
// the response register before its response is valid. The
// input stage register holds the request with codes clamped and the thousands
// digit of a set-integer value already split off. The response register is
// loaded from it through the lower decimal digits, code store update, scan and
// glyph lookup. A stalled response holds the stage, so at most two
// transactions wait inside and the request side then sees ready low.
// Writes change only the stored codes; the drive changes on ticks.
// dots_mode at byte address 0 selects which dots light.
`include "assert_macros.svh"

module four_digit_seven_segment_scanner
   import fdss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_value,
   input  logic [1:0]  req_digit_index,
   input  logic [4:0]  req_code_0,
   input  logic [4:0]  req_code_1,
   input  logic [4:0]  req_code_2,
   input  logic [4:0]  req_code_3,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_segments_n,
   output logic [3:0]  rsp_digit_enable_n,
   output logic [1:0]  rsp_scan_position,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [1:0]    dots_mode;
   split_type     split_front;
   req_stage_type stage_in;
   req_stage_type stage_ff;
   logic          stage_valid_ff;
   logic          stage_valid_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_take;
   logic          stage_adv;
   logic          req_take;
   codes_type     int_codes;
   codes_type     codes_ff;
   codes_type     codes_in;
   logic [1:0]    scan_ff;
   logic [1:0]    scan_in;
   logic [7:0]    held_seg_ff;
   logic [7:0]    held_seg_in;
   logic [3:0]    held_en_ff;
   logic [3:0]    held_en_in;
   logic [7:0]    drv_seg;
   logic [3:0]    drv_en;
   logic [7:0]    rsp_seg_ff;
   logic [3:0]    rsp_en_ff;
   logic [1:0]    rsp_scan_ff;
   logic          is_tick;
   logic          codes_ok;
   logic          en_ok;
   logic          tick_adv;
   logic          write_adv;
   logic [1:0]    scan_inc;
   logic [13:0]   drive_held;

   fdss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .dots_mode (dots_mode)
   );

   // front end: clamp codes and split off thousands before the stage register
   fdss_int_split u_split (
      .value (req_value),
      .split (split_front)
   );

   assign stage_in.func         = req_func;
   assign stage_in.digit_index  = req_digit_index;
   assign stage_in.single_code  = clamp_code(req_value);
   assign stage_in.all_codes[0] = clamp_code({11'd0, req_code_0});
   assign stage_in.all_codes[1] = clamp_code({11'd0, req_code_1});
   assign stage_in.all_codes[2] = clamp_code({11'd0, req_code_2});
   assign stage_in.all_codes[3] = clamp_code({11'd0, req_code_3});
   assign stage_in.split        = split_front;

   // flow control
   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign stage_adv = stage_valid_ff && out_take;
   assign req_ready = !stage_valid_ff || out_take;
   assign req_take  = req_valid && req_ready;

   assign stage_valid_in = req_take || (stage_valid_ff && !out_take);
   assign rsp_valid_in   = stage_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= stage_in;
      end
   end

   // lower decimal digits
   fdss_dec_low u_dec (
      .split (stage_ff.split),
      .codes (int_codes)
   );

   assign is_tick = (stage_ff.func == FUNC_TICK);

   // code store update
   always_comb begin
      codes_in = codes_ff;
      if (stage_adv) begin
         unique case (stage_ff.func)
            FUNC_TICK:      codes_in = codes_ff;
            FUNC_SET_INT:   codes_in = int_codes;
            FUNC_SET_DIGIT: codes_in[stage_ff.digit_index] = stage_ff.single_code;
            FUNC_SET_ALL:   codes_in = stage_ff.all_codes;
            default:        codes_in = codes_ff;
         endcase
      end
   end

   // scan advances first, then drive follows the new position
   assign scan_in = (stage_adv && is_tick) ? scan_ff + 2'd1 : scan_ff;

   fdss_drive u_drive (
      .codes          (codes_ff),
      .scan           (scan_in),
      .dots_mode      (dots_mode),
      .segments_n     (drv_seg),
      .digit_enable_n (drv_en)
   );

   assign held_seg_in = (stage_adv && is_tick) ? drv_seg : held_seg_ff;
   assign held_en_in  = (stage_adv && is_tick) ? drv_en  : held_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff    <= {NUM_DIGITS{CODE_DASH}};
         scan_ff     <= 2'd0;
         held_seg_ff <= 8'd0;
         held_en_ff  <= EN_ALL_OFF;
      end else begin
         codes_ff    <= codes_in;
         scan_ff     <= scan_in;
         held_seg_ff <= held_seg_in;
         held_en_ff  <= held_en_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_seg_ff  <= held_seg_in;
         rsp_en_ff   <= held_en_in;
         rsp_scan_ff <= scan_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segments_n     = rsp_seg_ff;
   assign rsp_digit_enable_n = rsp_en_ff;
   assign rsp_scan_position  = rsp_scan_ff;

   // terms for the checks
   assign codes_ok   = (codes_ff[0] <= CODE_MAX) && (codes_ff[1] <= CODE_MAX)
                    && (codes_ff[2] <= CODE_MAX) && (codes_ff[3] <= CODE_MAX);
   assign en_ok      = (held_en_ff == EN_ALL_OFF) || (held_en_ff == ~(4'b0001 << scan_ff));
   assign tick_adv   = stage_adv && is_tick;
   assign write_adv  = stage_adv && !is_tick;
   assign scan_inc   = scan_ff + 2'd1;
   assign drive_held = {held_seg_ff, held_en_ff, scan_ff};

   // checks
   `FDSS_ASSERT(a_codes_in_range, clock, reset, codes_ok, "stored code out of range")
   `FDSS_ASSERT(a_enable_tracks_scan, clock, reset, en_ok, "enable does not match scan")
   `FDSS_ASSERT(a_tick_advances, clock, reset, tick_adv |=> scan_ff == $past(scan_inc), "no advance")
   `FDSS_ASSERT(a_write_keeps_drive, clock, reset, write_adv |=> $stable(drive_held), "drive moved")

endmodule

// ===== tb/scanner_drive_checker.sv =====
module scanner_drive_checker
   import fdss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_value,
   input  logic [1:0]  req_digit_index,
   input  logic [4:0]  req_code_0,
   input  logic [4:0]  req_code_1,
   input  logic [4:0]  req_code_2,
   input  logic [4:0]  req_code_3,
   // response channel
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_segments_n,
   input  logic [3:0]  rsp_digit_enable_n,
   input  logic [1:0]  rsp_scan_position,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int unsigned outstanding,
   output int unsigned fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] segments_n;
      logic [3:0] digit_enable_n;
      logic [1:0] scan_position;
   } drive_t;

   // active-low patterns for codes 0..18, dot off
   localparam logic [18:0][7:0] GLYPHS = {
      8'hBF, 8'hC7, 8'hFF, 8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90,
      8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
   };

   code_type   shown_codes [NUM_DIGITS];
   logic [1:0] scan;
   logic [7:0] held_segments;
   logic [3:0] held_enables;
   logic [1:0] dots;
   drive_t     drive_q [$];

   // codes past dash are kept as blank
   function automatic code_type stored_code(input logic [15:0] c);
      if (c > 16'(CODE_MAX)) return CODE_BLANK;
      return c[CODE_W-1:0];
   endfunction

   // update the display state for one request and return the held drive
   task automatic apply_request(input logic [1:0] func, input logic [15:0] value,
                                input logic [1:0] index, input code_type c0,
                                input code_type c1, input code_type c2,
                                input code_type c3, output drive_t shown);
      int unsigned n;
      logic [7:0]  seg;
      n = value;
      case (func)
         FUNC_TICK: begin
            scan = scan + 2'd1;
            seg  = GLYPHS[shown_codes[scan]];
            if (scan == 2'd2 && (dots == DOTS_BOTH || dots == DOTS_UPPER)) seg[7] = 1'b0;
            if (scan == 2'd3 && (dots == DOTS_BOTH || dots == DOTS_LOWER)) seg[7] = 1'b0;
            held_segments = seg;
            held_enables  = ~(4'b0001 << scan);
         end
         FUNC_SET_INT: begin
            if (value > INT_MAX_SHOWN) begin
               shown_codes[0] = CODE_BLANK;
               shown_codes[1] = CODE_BLANK;
               shown_codes[2] = CODE_ZERO;
               shown_codes[3] = CODE_L;
            end else begin
               shown_codes[0] = code_type'(n / 1000);
               shown_codes[1] = code_type'((n % 1000) / 100);
               shown_codes[2] = code_type'((n % 100) / 10);
               shown_codes[3] = code_type'(n % 10);
            end
         end
         FUNC_SET_DIGIT: shown_codes[index] = stored_code(value);
         default: begin
            shown_codes[0] = stored_code({11'b0, c0});
            shown_codes[1] = stored_code({11'b0, c1});
            shown_codes[2] = stored_code({11'b0, c2});
            shown_codes[3] = stored_code({11'b0, c3});
         end
      endcase
      shown.segments_n     = held_segments;
      shown.digit_enable_n = held_enables;
      shown.scan_position  = scan;
   endtask

   always @(posedge clock) begin : monitor
      drive_t want;
      if (reset) begin
         foreach (shown_codes[i]) shown_codes[i] = CODE_DASH;
         scan          = 2'd0;
         held_segments = 8'h00;
         held_enables  = EN_ALL_OFF;
         dots          = DOTS_OFF;
         drive_q.delete();
         outstanding   = 0;
      end else begin
         // register accesses
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == REG_DOTS_MODE) dots = pwdata[1:0];
            end else if (paddr == REG_DOTS_MODE && prdata !== {30'b0, dots}) begin
               $error("prdata: expected %h, actual %h", {30'b0, dots}, prdata);
               fail_count++;
            end
         end
         // response transaction against the oldest prediction
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (drive_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = drive_q.pop_front();
               if (rsp_segments_n !== want.segments_n) begin
                  $error("segments_n: expected %h, actual %h",
                         want.segments_n, rsp_segments_n);
                  fail_count++;
               end
               if (rsp_digit_enable_n !== want.digit_enable_n) begin
                  $error("digit_enable_n: expected %h, actual %h",
                         want.digit_enable_n, rsp_digit_enable_n);
                  fail_count++;
               end
               if (rsp_scan_position !== want.scan_position) begin
                  $error("scan_position: expected %0d, actual %0d",
                         want.scan_position, rsp_scan_position);
                  fail_count++;
               end
            end
         end
         // request transaction
         if (req_valid && req_ready) begin
            apply_request(req_func, req_value, req_digit_index, req_code_0,
                          req_code_1, req_code_2, req_code_3, want);
            drive_q.push_back(want);
         end
         outstanding = drive_q.size();
      end
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   import fdss_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 11;
   localparam int PHASE_ITEMS = 100;
   localparam logic [1:0] DOTS_ORDER [4] = '{DOTS_OFF, DOTS_UPPER, DOTS_LOWER, DOTS_BOTH};

   typedef enum logic [1:0] {PACE_FULL, PACE_COIN, PACE_HICCUP, PACE_SLOW} rsp_pace_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_TICK;
   logic [15:0] req_value = '0;
   logic [1:0]  req_digit_index = '0;
   logic [4:0]  req_code_0 = '0;
   logic [4:0]  req_code_1 = '0;
   logic [4:0]  req_code_2 = '0;
   logic [4:0]  req_code_3 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_segments_n;
   logic [3:0]  rsp_digit_enable_n;
   logic [1:0]  rsp_scan_position;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = REG_DOTS_MODE;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned cycle_count = 0;
   int          burst_left = 0;
   rsp_pace_t   rsp_pace = PACE_FULL;
   int          pace_left = 0;

   four_digit_seven_segment_scanner u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_value          (req_value),
      .req_digit_index    (req_digit_index),
      .req_code_0         (req_code_0),
      .req_code_1         (req_code_1),
      .req_code_2         (req_code_2),
      .req_code_3         (req_code_3),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_segments_n     (rsp_segments_n),
      .rsp_digit_enable_n (rsp_digit_enable_n),
      .rsp_scan_position  (rsp_scan_position),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   scanner_drive_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side: the stall pattern is redrawn when its random hold count runs out
   always @(posedge clock) begin
      if (pace_left == 0) begin
         rsp_pace  <= rsp_pace_t'($urandom_range(0, 3));
         pace_left <= $urandom_range(50, 300);
      end else begin
         pace_left <= pace_left - 1;
      end
      case (rsp_pace)
         PACE_FULL:   rsp_ready <= 1'b1;
         PACE_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
         PACE_HICCUP: rsp_ready <= ($urandom_range(0, 7) != 0);
         default:     rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // one request transaction; idles between bursts
   task automatic send_request(input logic [1:0] func, input logic [15:0] value,
                               input logic [1:0] index, input code_type c0,
                               input code_type c1, input code_type c2,
                               input code_type c3);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_value       <= value;
      req_digit_index <= index;
      req_code_0      <= c0;
      req_code_1      <= c1;
      req_code_2      <= c2;
      req_code_3      <= c3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_ticks(input int count);
      repeat (count)
         send_request(FUNC_TICK, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                      5'd31, 5'd0, 5'd31, 5'd0);
   endtask

   // dots mode write and read-back, only with the pipeline drained
   task automatic set_dots_mode(input logic [1:0] mode);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_DOTS_MODE;
      pwdata  <= {30'b0, mode};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic random_request();
      logic [1:0]  func;
      logic [15:0] value;
      code_type    codes [NUM_DIGITS];
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      func = FUNC_TICK;
      else if (pick < 65) func = FUNC_SET_INT;
      else if (pick < 85) func = FUNC_SET_DIGIT;
      else                func = FUNC_SET_ALL;
      value = 16'($urandom_range(0, 65535));
      if (func == FUNC_SET_INT) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)       value = 16'($urandom_range(0, 9999));
         else if (pick == 6) value = INT_MAX_SHOWN;
         else if (pick == 7) value = INT_MAX_SHOWN + 16'd1;
      end else if (func == FUNC_SET_DIGIT && $urandom_range(0, 9) < 7) begin
         value = 16'($urandom_range(0, CODE_MAX));
      end
      foreach (codes[i])
         codes[i] = ($urandom_range(0, 4) != 0) ? code_type'($urandom_range(0, CODE_MAX))
                                                : code_type'($urandom_range(0, 31));
      send_request(func, value, 2'($urandom_range(0, 3)),
                   codes[0], codes[1], codes[2], codes[3]);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset dashes, overload, extremes, clamping, wrap, dots
      send_ticks(1);
      set_dots_mode(DOTS_BOTH);
      send_request(FUNC_SET_INT, 16'd10000, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0);
      send_ticks(4);
      send_request(FUNC_SET_INT, INT_MAX_SHOWN, 2'd3, 5'd31, 5'd31, 5'd31, 5'd31);
      send_ticks(4);
      send_request(FUNC_SET_INT, 16'd0, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0);
      send_request(FUNC_SET_INT, 16'hFFFF, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0);
      send_request(FUNC_SET_DIGIT, 16'd19, 2'd0, 5'd0, 5'd0, 5'd0, 5'd0);
      send_request(FUNC_SET_DIGIT, 16'hFFFF, 2'd1, 5'd31, 5'd31, 5'd31, 5'd31);
      send_request(FUNC_SET_DIGIT, 16'(CODE_L), 2'd2, 5'd0, 5'd0, 5'd0, 5'd0);
      send_request(FUNC_SET_DIGIT, 16'(CODE_DASH), 2'd3, 5'd0, 5'd0, 5'd0, 5'd0);
      send_ticks(2);
      send_request(FUNC_SET_ALL, 16'hFFFF, 2'd3, 5'd0, 5'd31, 5'd15, 5'd19);
      send_ticks(4);

      // random phases across every dots mode
      for (int ph = 0; ph < PHASES; ph++) begin
         set_dots_mode(DOTS_ORDER[ph % 4]);
         repeat (PHASE_ITEMS) random_request();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== four_digit_seven_segment_scanner.f =====
+incdir+rtl/core
rtl/core/fdss_pkg.sv
rtl/core/fdss_csr.sv
rtl/core/fdss_int_split.sv
rtl/core/fdss_dec_low.sv
rtl/core/fdss_drive.sv
rtl/core/four_digit_seven_segment_scanner.sv
tb/scanner_drive_checker.sv
tb/tb.sv
